### rtl/cascaded_attitude_pid_macros.svh
// Assertion macros for the attitude controller.
`ifndef CASCADED_ATTITUDE_PID_MACROS_SVH
`define CASCADED_ATTITUDE_PID_MACROS_SVH
`ifndef SYNTH
`define CAP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAP_ASSERT_IMPL(lbl, ante, cons)
`define CAP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/cap_pkg.sv
package cap_pkg;

    typedef enum logic [3:0] {
        S_IDLE, S_CONV, S_CONV_W, S_P, S_P_W, S_I, S_I_W, S_T, S_T_W,
        S_D, S_D_W, S_DIV, S_INNER, S_OUT
    } cap_state_t;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_OUTER_YAW   = 3'd0;
    localparam cfg_index_t CFG_INNER_YAW   = 3'd3;
    localparam cfg_index_t CFG_DT          = 3'd6;

    localparam logic signed [32:0] DEG2RAD_Q32 = 33'sd74961321;
    localparam logic signed [32:0] DECAY_Q16   = 33'sd19661;
    localparam logic signed [32:0] OUTER_THR   = 33'sd26214;
    localparam logic signed [32:0] INNER_THR   = 33'sd98304;
    localparam logic signed [65:0] INT_LIMIT   = 66'sd131072;
    localparam logic [31:0]        DT_FLOOR    = 32'd17;

    localparam int DIV_NUM_W = 62;

    localparam logic [47:0] RST_OUTER_YAW   = 48'd1760936591380;
    localparam logic [47:0] RST_OUTER_PITCH = 48'd2637109919949;
    localparam logic [47:0] RST_OUTER_ROLL  = 48'd3517578215629;
    localparam logic [47:0] RST_INNER_YAW   = 48'd19353659506893;
    localparam logic [47:0] RST_INNER_PITCH = 48'd17592454480077;
    localparam logic [47:0] RST_INNER_ROLL  = 48'd7035290648986;
    localparam logic [31:0] RST_DT          = 32'd16777216;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_int(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > INT_LIMIT)
            r = 32'sd131072;
        else if (v < -INT_LIMIT)
            r = -32'sd131072;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/cascaded_attitude_pid.sv
// Channel   Handshake              Carries
// input     in_valid / in_ready    op, targets, measured angles, gyro rates
// output    out_valid / out_ready  drive_yaw, drive_pitch, drive_roll
// config    cfg_we                 cfg_index, cfg_data
// A control tick keeps the block busy after its input beat: each of
// six axis steps runs a division for the derivative term plus products
// on the one 33 by 33 multiplier. The result beat is registered from S_OUT once the
// output register is free. A clear op zeroes the integrators and gives no beat.
// Reset loads the default gains and period and clears integrators and last errors.
// One result beat can wait in the output register while the next tick runs.
module cascaded_attitude_pid
    import cap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] target_yaw,
    input  logic signed [31:0] target_pitch,
    input  logic signed [31:0] target_roll,
    input  logic signed [31:0] meas_pitch_deg,
    input  logic signed [31:0] meas_roll_deg,
    input  logic signed [31:0] meas_yaw_deg,
    input  logic signed [31:0] gyro_x,
    input  logic signed [31:0] gyro_y,
    input  logic signed [31:0] gyro_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive_yaw,
    output logic signed [31:0] drive_pitch,
    output logic signed [31:0] drive_roll,
    input  logic               cfg_we,
    input  cap_pkg::cfg_index_t cfg_index,
    input  logic [47:0]        cfg_data
);
    `include "cascaded_attitude_pid_macros.svh"

    cap_state_t state_reg, state_next;

    logic              loop_reg;
    logic [1:0]        axis_reg;
    logic [47:0]       gains_reg [2][3];
    logic [31:0]       dt_reg;
    logic signed [31:0] integ_reg [2][3];
    logic signed [31:0] last_reg [2][3];

    logic signed [31:0] tar_reg [3];
    logic signed [31:0] meas_reg [3];
    logic signed [31:0] gx_reg, gy_reg, gz_reg;
    logic signed [31:0] err_reg [3];
    logic signed [31:0] ctrl_reg [3];
    logic signed [63:0] acc_reg;
    logic signed [31:0] t_reg;
    logic               neg_reg;
    logic signed [65:0] prod_reg;

    logic               out_valid_reg;
    logic signed [31:0] drive_yaw_reg, drive_pitch_reg, drive_roll_reg;
    logic               out_load;

    logic signed [32:0] mul_a, mul_b;
    logic               accept, div_start, div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic signed [31:0] e, integ_cur, last_cur, integ_new;
    logic signed [32:0] e_ext, e_mag, diff, thr;
    logic               sep, bonus;
    logic [47:0]        gains;
    logic [15:0]        kp, ki, kd;
    logic [31:0]        safe_dt;
    logic signed [65:0] prod_r12, prod_r16, prod_r24, prod_r32, sum66;
    logic signed [63:0] q, num64, dterm;
    logic [63:0]        num_mag;

    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign e         = err_reg[axis_reg];
    assign e_ext     = {e[31], e};
    assign e_mag     = e[31] ? -e_ext : e_ext;
    assign integ_cur = integ_reg[loop_reg][axis_reg];
    assign last_cur  = last_reg[loop_reg][axis_reg];
    assign diff      = e_ext - {last_cur[31], last_cur};
    assign thr       = loop_reg ? INNER_THR : OUTER_THR;
    assign sep       = e_mag > thr;
    assign gains     = gains_reg[loop_reg][axis_reg];
    assign kp        = gains[47:32];
    assign ki        = gains[31:16];
    assign kd        = gains[15:0];
    assign safe_dt   = (dt_reg > DT_FLOOR) ? dt_reg : DT_FLOOR;
    assign bonus     = (axis_reg == 2'd1) && !diff[32] && (diff != '0);

    assign prod_r12 = (prod_reg + 66'sd2048) >>> 12;
    assign prod_r16 = (prod_reg + 66'sd32768) >>> 16;
    assign prod_r24 = (prod_reg + 66'sd8388608) >>> 24;
    assign prod_r32 = (prod_reg + 66'sd2147483648) >>> 32;

    assign q       = prod_reg[63:0];
    assign num64   = bonus ? (((q <<< 1) + q) <<< 11) : (q <<< 12);
    assign num_mag = num64[63] ? (~num64 + 64'd1) : num64;
    assign dterm   = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    assign sum66   = {{2{acc_reg[63]}}, acc_reg} + {{2{dterm[63]}}, dterm};

    always_comb
    begin
        if (state_reg == S_I_W)
            integ_new = clamp_int(prod_r16);
        else
            integ_new = clamp_int({{34{integ_cur[31]}}, integ_cur} + prod_r24);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept && !op) state_next = S_CONV;
            S_CONV:   state_next = S_CONV_W;
            S_CONV_W: state_next = (axis_reg == 2'd2) ? S_P : S_CONV;
            S_P:      state_next = S_P_W;
            S_P_W:    state_next = S_I;
            S_I:      state_next = S_I_W;
            S_I_W:    state_next = sep ? S_D : S_T;
            S_T:      state_next = S_T_W;
            S_T_W:    state_next = S_D;
            S_D:      state_next = S_D_W;
            S_D_W:    state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg != 2'd2)
                        state_next = S_P;
                    else
                        state_next = loop_reg ? S_OUT : S_INNER;
                end
            end
            S_INNER:  state_next = S_P;
            S_OUT:    if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_CONV:
            begin
                mul_a = {meas_reg[axis_reg][31], meas_reg[axis_reg]};
                mul_b = DEG2RAD_Q32;
            end
            S_P:
            begin
                mul_a = e_ext;
                mul_b = {17'd0, kp};
            end
            S_I:
            begin
                if (sep)
                begin
                    mul_a = {integ_cur[31], integ_cur};
                    mul_b = DECAY_Q16;
                end
                else
                begin
                    mul_a = e_ext;
                    mul_b = {17'd0, ki};
                end
            end
            S_T:
            begin
                mul_a = {t_reg[31], t_reg};
                mul_b = {1'b0, dt_reg};
            end
            S_D:
            begin
                mul_a = diff;
                mul_b = {17'd0, kd};
            end
            S_D_W: div_start = 1'b1;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            loop_reg  <= 1'b0;
            axis_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
            gains_reg[0][0] <= RST_OUTER_YAW;
            gains_reg[0][1] <= RST_OUTER_PITCH;
            gains_reg[0][2] <= RST_OUTER_ROLL;
            gains_reg[1][0] <= RST_INNER_YAW;
            gains_reg[1][1] <= RST_INNER_PITCH;
            gains_reg[1][2] <= RST_INNER_ROLL;
            dt_reg <= RST_DT;
            for (int l = 0; l < 2; l++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    integ_reg[l][a] <= '0;
                    last_reg[l][a]  <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index < CFG_INNER_YAW)
                    gains_reg[0][cfg_index[1:0]] <= cfg_data;
                else if (cfg_index < CFG_DT)
                    gains_reg[1][2'(cfg_index - CFG_INNER_YAW)] <= cfg_data;
                else if (cfg_index == CFG_DT)
                    dt_reg <= cfg_data[31:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    loop_reg <= 1'b0;
                    axis_reg <= 2'd0;
                    if (accept && op)
                    begin
                        for (int l = 0; l < 2; l++)
                        begin
                            for (int a = 0; a < 3; a++)
                                integ_reg[l][a] <= '0;
                        end
                    end
                end
                S_CONV_W: axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                S_I_W:
                begin
                    if (sep)
                        integ_reg[loop_reg][axis_reg] <= integ_new;
                end
                S_T_W: integ_reg[loop_reg][axis_reg] <= integ_new;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        last_reg[loop_reg][axis_reg] <= e;
                        if (axis_reg == 2'd2)
                        begin
                            axis_reg <= 2'd0;
                            loop_reg <= !loop_reg;
                        end
                        else
                            axis_reg <= axis_reg + 2'd1;
                    end
                end
                default:
                begin
                    axis_reg <= axis_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (out_load)
        begin
            drive_yaw_reg   <= ctrl_reg[0];
            drive_pitch_reg <= ctrl_reg[1];
            drive_roll_reg  <= ctrl_reg[2];
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tar_reg[0]  <= target_yaw;
                    tar_reg[1]  <= target_pitch;
                    tar_reg[2]  <= target_roll;
                    meas_reg[0] <= meas_yaw_deg;
                    meas_reg[1] <= meas_pitch_deg;
                    meas_reg[2] <= meas_roll_deg;
                    gx_reg      <= gyro_x;
                    gy_reg      <= gyro_y;
                    gz_reg      <= gyro_z;
                end
            end
            S_CONV_W:
                err_reg[axis_reg] <= sat32({{34{tar_reg[axis_reg][31]}}, tar_reg[axis_reg]}
                                           - prod_r32);
            S_P_W: acc_reg <= prod_r12[63:0];
            S_I_W:
            begin
                if (sep)
                    acc_reg <= acc_reg + {{32{integ_new[31]}}, integ_new};
                else
                    t_reg <= sat32(prod_r12);
            end
            S_T_W: acc_reg <= acc_reg + {{32{integ_new[31]}}, integ_new};
            S_D_W: neg_reg <= num64[63];
            S_DIV:
            begin
                if (div_done)
                    ctrl_reg[axis_reg] <= sat32(sum66);
            end
            S_INNER:
            begin
                err_reg[0] <= sat32({{34{tar_reg[0][31]}}, tar_reg[0]}
                                    - {{34{gz_reg[31]}}, gz_reg});
                err_reg[1] <= sat32({{34{ctrl_reg[1][31]}}, ctrl_reg[1]}
                                    - {{34{gy_reg[31]}}, gy_reg});
                err_reg[2] <= sat32({{34{ctrl_reg[2][31]}}, ctrl_reg[2]}
                                    - {{34{gx_reg[31]}}, gx_reg});
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    cap_div #(
        .NUM_W(DIV_NUM_W),
        .DEN_W(32)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_mag[DIV_NUM_W-1:0]),
        .den   (safe_dt),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_valid   = out_valid_reg;
    assign drive_yaw   = drive_yaw_reg;
    assign drive_pitch = drive_pitch_reg;
    assign drive_roll  = drive_roll_reg;

    `CAP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_pitch))
    `CAP_ASSERT_NEXT(a_div_wait, div_start, state_reg == S_DIV)
    `CAP_ASSERT_IMPL(a_done_in_div, div_done, state_reg == S_DIV)
    `CAP_ASSERT_IMPL(a_integ_bound, state_reg == S_OUT, integ_reg[1][1] <= 32'sd131072)
endmodule

### rtl/cap_div.sv
module cap_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
